// ===== hw/rtl/ckb_pkg.sv =====
package ckb_pkg;

	localparam int SCREEN_COLS  = 240;
	localparam int SCREEN_LINES = 160;
	localparam int STORE_DEPTH  = SCREEN_COLS * SCREEN_LINES;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int COL_W        = $clog2(SCREEN_COLS);
	localparam int ROW_W        = $clog2(SCREEN_LINES);
	// signed position plus unsigned size
	localparam int COORD_W      = 12;

	typedef enum logic [1:0] {
		OP_FILL   = 2'd0,
		OP_HEADER = 2'd1,
		OP_PIXEL  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [9:0]  pos_x;
		logic signed [9:0]  pos_y;
		logic [8:0]         width;
		logic [8:0]         height;
		logic [7:0]         pixel_value;
		logic [15:0]        read_address;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
		logic       sprite_done;
	} result_t;

	typedef struct packed {
		logic take;
		logic fill_run;
		logic read_load;
	} cmd_t;

	typedef struct packed {
		logic is_fill;
		logic is_read;
		logic fill_empty;
		logic fill_last;
	} stat_t;

endpackage

// ===== hw/rtl/ckb_if.sv =====
interface ckb_req_if;
	logic                 valid;
	logic                 ready;
	ckb_pkg::op_t         op;
	logic signed [9:0]    pos_x;
	logic signed [9:0]    pos_y;
	logic [8:0]           width;
	logic [8:0]           height;
	logic [7:0]           pixel_value;
	logic [15:0]          read_address;

	modport source (
		output valid, op, pos_x, pos_y, width, height, pixel_value, read_address,
		input  ready
	);
	modport sink (
		input  valid, op, pos_x, pos_y, width, height, pixel_value, read_address,
		output ready
	);
endinterface

interface ckb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       status;
	logic       sprite_done;

	modport source (
		output valid, read_data, status, sprite_done,
		input  ready
	);
	modport sink (
		input  valid, read_data, status, sprite_done,
		output ready
	);
endinterface

// ===== hw/rtl/ckb_ram.sv =====
module ckb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/ckb_ctrl.sv =====
module ckb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_ready,
	input  ckb_pkg::stat_t stat,
	output logic           in_ready,
	output logic           out_valid,
	output ckb_pkg::cmd_t  cmd
);

	ckb_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ckb_pkg::ST_IDLE: begin
				if (cmd.take && stat.is_read) begin
					state_d = ckb_pkg::ST_READ;
				end else if (cmd.take && stat.is_fill && !stat.fill_empty) begin
					state_d = ckb_pkg::ST_FILL;
				end
			end
			ckb_pkg::ST_FILL: begin
				if (stat.fill_last) begin
					state_d = ckb_pkg::ST_IDLE;
				end
			end
			ckb_pkg::ST_READ: begin
				state_d = ckb_pkg::ST_IDLE;
			end
			default: begin
				state_d = ckb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ckb_pkg::ST_IDLE) && (!out_valid_q || out_ready);
		cmd.take      = in_valid && in_ready;
		cmd.fill_run  = (state_q == ckb_pkg::ST_FILL);
		cmd.read_load = (state_q == ckb_pkg::ST_READ);
	end

	// results ready at once: header, pixel, empty fill
	assign load = (cmd.take && !stat.is_read && !(stat.is_fill && !stat.fill_empty))
		|| cmd.read_load || (cmd.fill_run && stat.fill_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ckb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/ckb_datapath.sv =====
module ckb_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ckb_pkg::item_t   item,
	input  ckb_pkg::cmd_t    cmd,
	output ckb_pkg::stat_t   stat,
	output ckb_pkg::result_t result
);

	localparam int CW = ckb_pkg::COORD_W;
	localparam int AW = ckb_pkg::ADDR_W;
	localparam logic signed [CW-1:0] COLS_S  = CW'(ckb_pkg::SCREEN_COLS);
	localparam logic signed [CW-1:0] LINES_S = CW'(ckb_pkg::SCREEN_LINES);
	localparam logic [AW-1:0]        COLS_A  = AW'(ckb_pkg::SCREEN_COLS);

	// sprite state
	logic signed [9:0] origin_col_q, origin_row_q;
	logic [8:0]        sprite_cols_q, sprite_rows_q;
	logic [8:0]        cursor_col_q, cursor_row_q;
	logic              sprite_open_q;

	// fill sweep
	logic [ckb_pkg::COL_W-1:0] col_q, x0_q, x_last_q;
	logic [ckb_pkg::ROW_W-1:0] row_q, y_last_q;
	logic [AW-1:0]             row_base_q, fill_addr_q;
	logic [7:0]                colour_q;
	logic                      in_range_q;

	logic [7:0]        rd_q;
	logic              status_q, done_q;
	logic [7:0]        ram_rdata;

	logic signed [CW-1:0] xs, ys, xe, ye, x0c, y0c, x1c, y1c;
	logic signed [CW-1:0] sx, sy;
	logic                 fill_empty;
	logic                 pix_on, pix_write, col_end, row_end, stray, pix_done;
	logic [AW-1:0]        pix_addr, fill_base;
	logic                 in_range;
	logic                 is_fill, is_header, is_pixel, is_read;
	logic                 we, re;
	logic [AW-1:0]        waddr;
	logic [7:0]           wdata;

	always_comb begin
		is_fill   = (item.op == ckb_pkg::OP_FILL);
		is_header = (item.op == ckb_pkg::OP_HEADER);
		is_pixel  = (item.op == ckb_pkg::OP_PIXEL);
		is_read   = (item.op == ckb_pkg::OP_READ);

		// rectangle clip
		xs  = CW'(item.pos_x);
		ys  = CW'(item.pos_y);
		xe  = xs + $signed({3'b000, item.width});
		ye  = ys + $signed({3'b000, item.height});
		x0c = (xs < 0) ? '0 : xs;
		y0c = (ys < 0) ? '0 : ys;
		x1c = (xe > COLS_S) ? COLS_S : xe;
		y1c = (ye > LINES_S) ? LINES_S : ye;
		fill_empty = (item.width == '0) || (item.height == '0) || (x0c >= x1c) || (y0c >= y1c);
		fill_base  = AW'(y0c[ckb_pkg::ROW_W-1:0]) * COLS_A + AW'(x0c[ckb_pkg::COL_W-1:0]);

		// sprite pixel position
		sx = CW'(origin_col_q) + $signed({3'b000, cursor_col_q});
		sy = CW'(origin_row_q) + $signed({3'b000, cursor_row_q});
		pix_on = (sx >= 0) && (sx < COLS_S) && (sy >= 0) && (sy < LINES_S);
		pix_addr = AW'(sy[ckb_pkg::ROW_W-1:0]) * COLS_A + AW'(sx[ckb_pkg::COL_W-1:0]);
		pix_write = cmd.take && is_pixel && sprite_open_q && pix_on && (item.pixel_value != '0);
		col_end = ({1'b0, cursor_col_q} + 10'd1) >= {1'b0, sprite_cols_q};
		row_end = ({1'b0, cursor_row_q} + 10'd1) >= {1'b0, sprite_rows_q};
		stray    = is_pixel && !sprite_open_q;
		pix_done = is_pixel && sprite_open_q && col_end && row_end;

		in_range = 32'(item.read_address) < ckb_pkg::STORE_DEPTH;

		we    = pix_write || cmd.fill_run;
		waddr = cmd.fill_run ? fill_addr_q : pix_addr;
		wdata = cmd.fill_run ? colour_q : item.pixel_value;
		re    = cmd.take && is_read && in_range;

		stat.is_fill    = is_fill;
		stat.is_read    = is_read;
		stat.fill_empty = fill_empty;
		stat.fill_last  = (col_q == x_last_q) && (row_q == y_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q  <= '0;
			origin_row_q  <= '0;
			sprite_cols_q <= '0;
			sprite_rows_q <= '0;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			sprite_open_q <= 1'b0;
		end else if (cmd.take && is_header) begin
			origin_col_q  <= item.pos_x;
			origin_row_q  <= item.pos_y;
			sprite_cols_q <= item.width;
			sprite_rows_q <= item.height;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			sprite_open_q <= (item.width != '0) && (item.height != '0);
		end else if (cmd.take && is_pixel && sprite_open_q) begin
			if (col_end) begin
				cursor_col_q <= '0;
				if (row_end) begin
					cursor_row_q  <= '0;
					sprite_open_q <= 1'b0;
				end else begin
					cursor_row_q <= cursor_row_q + 9'd1;
				end
			end else begin
				cursor_col_q <= cursor_col_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x0_q       <= x0c[ckb_pkg::COL_W-1:0];
			col_q      <= x0c[ckb_pkg::COL_W-1:0];
			x_last_q   <= ckb_pkg::COL_W'(x1c - CW'(1));
			row_q      <= y0c[ckb_pkg::ROW_W-1:0];
			y_last_q   <= ckb_pkg::ROW_W'(y1c - CW'(1));
			row_base_q <= fill_base;
			fill_addr_q <= fill_base;
			colour_q   <= item.pixel_value;
			in_range_q <= in_range;
			rd_q       <= '0;
			status_q   <= stray;
			done_q     <= pix_done;
		end else if (cmd.fill_run) begin
			if (col_q == x_last_q) begin
				col_q       <= x0_q;
				row_q       <= row_q + ckb_pkg::ROW_W'(1);
				row_base_q  <= row_base_q + COLS_A;
				fill_addr_q <= row_base_q + COLS_A;
			end else begin
				col_q       <= col_q + ckb_pkg::COL_W'(1);
				fill_addr_q <= fill_addr_q + AW'(1);
			end
		end else if (cmd.read_load) begin
			rd_q <= in_range_q ? ram_rdata : '0;
		end
	end

	ckb_ram #(
		.WIDTH(8),
		.DEPTH(ckb_pkg::STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (AW'(item.read_address)),
		.rdata (ram_rdata)
	);

	assign result.read_data   = rd_q;
	assign result.status      = status_q;
	assign result.sprite_done = done_q;

endmodule

// ===== hw/rtl/clipped_fill_and_keyed_blit.sv =====
// Clipped fill and color-keyed sprite blitter over an 8-bit indexed frame store
// of SCREEN_COLS x SCREEN_LINES bytes, row-major. Every item gives one result.
// Sprite header and sprite pixel items load their result at once. A read goes
// through the registered read port of the frame store, then the result
// register. A fill writes its clipped rectangle byte by byte, since the frame
// store has a single write port; a fill that clips to nothing loads its result
// at once. A finished result waits in an output register, and the next item is
// accepted in the same cycle that result is taken. The frame store has no reset
// and no clearing pass: bytes read before they are written come back undefined.
module clipped_fill_and_keyed_blit (
	input  logic             clk,
	input  logic             arst_n,
	ckb_req_if.sink          req,
	ckb_rsp_if.source        rsp
);

	ckb_pkg::item_t   item;
	ckb_pkg::cmd_t    cmd;
	ckb_pkg::stat_t   stat;
	ckb_pkg::result_t result;

	assign item.op           = req.op;
	assign item.pos_x        = req.pos_x;
	assign item.pos_y        = req.pos_y;
	assign item.width        = req.width;
	assign item.height       = req.height;
	assign item.pixel_value  = req.pixel_value;
	assign item.read_address = req.read_address;

	ckb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	ckb_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	assign rsp.read_data   = result.read_data;
	assign rsp.status      = result.status;
	assign rsp.sprite_done = result.sprite_done;

	a_no_take_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("item accepted while result is blocked");

	a_read_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.op == ckb_pkg::OP_READ |=> !req.ready ##1 rsp.valid)
		else $error("read result not valid two cycles after the item");

	a_done_not_stray: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.sprite_done && rsp.status))
		else $error("sprite done flagged on a stray pixel");

endmodule

// ===== bench/ckb_blit_checker.sv =====
`timescale 1ns / 1ps

module ckb_blit_checker
	import ckb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ckb_req_if   req,
	ckb_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	logic [7:0]        frame [STORE_DEPTH];
	logic signed [9:0] org_col;
	logic signed [9:0] org_row;
	logic [8:0]        spr_cols;
	logic [8:0]        spr_rows;
	logic [8:0]        cur_col;
	logic [8:0]        cur_row;
	logic              spr_open;
	result_t           expected_results[$];

	initial begin
		errors   = 0;
		pending  = 0;
		org_col  = '0;
		org_row  = '0;
		spr_cols = '0;
		spr_rows = '0;
		cur_col  = '0;
		cur_row  = '0;
		spr_open = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++)
			frame[i] = '0;
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// applies the item to the frame and sprite model and returns the result it should give
	function automatic result_t blit_item(input item_t it);
		result_t           r;
		logic signed [9:0] px;
		logic signed [9:0] py;
		int                xi, yi, wi, hi;
		int                x0, y0, x1, y1;
		int                sx, sy;
		r  = '0;
		px = it.pos_x;
		py = it.pos_y;
		xi = px;
		yi = py;
		wi = it.width;
		hi = it.height;
		case (it.op)
			OP_FILL: begin
				if (wi != 0 && hi != 0) begin
					x0 = xi < 0 ? 0 : xi;
					y0 = yi < 0 ? 0 : yi;
					x1 = xi + wi > SCREEN_COLS ? SCREEN_COLS : xi + wi;
					y1 = yi + hi > SCREEN_LINES ? SCREEN_LINES : yi + hi;
					for (int row = y0; row < y1; row++)
						for (int col = x0; col < x1; col++)
							frame[row * SCREEN_COLS + col] = it.pixel_value;
				end
			end
			OP_HEADER: begin
				org_col  = px;
				org_row  = py;
				spr_cols = it.width;
				spr_rows = it.height;
				cur_col  = '0;
				cur_row  = '0;
				spr_open = (wi != 0 && hi != 0);
			end
			OP_PIXEL: begin
				if (!spr_open) begin
					r.status = 1'b1;
				end else begin
					xi = org_col;
					yi = org_row;
					wi = cur_col;
					hi = cur_row;
					sx = xi + wi;
					sy = yi + hi;
					if (it.pixel_value != 0 && sx >= 0 && sx < SCREEN_COLS
							&& sy >= 0 && sy < SCREEN_LINES)
						frame[sy * SCREEN_COLS + sx] = it.pixel_value;
					cur_col = cur_col + 9'd1;
					if (cur_col >= spr_cols) begin
						cur_col = '0;
						cur_row = cur_row + 9'd1;
						if (cur_row >= spr_rows) begin
							cur_row       = '0;
							spr_open      = 1'b0;
							r.sprite_done = 1'b1;
						end
					end
				end
			end
			default: begin
				if (int'(it.read_address) < STORE_DEPTH)
					r.read_data = frame[it.read_address];
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		item_t   it;
		result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report("result with no item waiting", rsp.read_data, 8'h00);
				end else begin
					want = expected_results.pop_front();
					if (rsp.read_data !== want.read_data)
						report("read_data", rsp.read_data, want.read_data);
					if (rsp.status !== want.status)
						report("status", {7'd0, rsp.status}, {7'd0, want.status});
					if (rsp.sprite_done !== want.sprite_done)
						report("sprite_done", {7'd0, rsp.sprite_done}, {7'd0, want.sprite_done});
				end
			end
			if (req.valid && req.ready) begin
				it.op           = req.op;
				it.pos_x        = req.pos_x;
				it.pos_y        = req.pos_y;
				it.width        = req.width;
				it.height       = req.height;
				it.pixel_value  = req.pixel_value;
				it.read_address = req.read_address;
				expected_results.push_back(blit_item(it));
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== bench/tb_clipped_fill_and_keyed_blit.sv =====
`timescale 1ns / 1ps

module tb_clipped_fill_and_keyed_blit;

	import ckb_pkg::*;

	localparam int STALL_LIMIT = 150000;
	localparam int RANDOM_ITEMS = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   sent = 0;
	int   quiet = 0;
	int   chk_errors;
	int   chk_pending;

	ckb_req_if req_if ();
	ckb_rsp_if rsp_if ();

	clipped_fill_and_keyed_blit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ckb_blit_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	always #6 clk = ~clk;

	initial begin
		req_if.valid        = 1'b0;
		req_if.op           = OP_FILL;
		req_if.pos_x        = '0;
		req_if.pos_y        = '0;
		req_if.width        = '0;
		req_if.height       = '0;
		req_if.pixel_value  = '0;
		req_if.read_address = '0;
		rsp_if.ready        = 1'b0;
	end

	always @(posedge clk)
		rsp_if.ready <= calm || ($urandom_range(99) >= 35);

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic item_t mk(input op_t op, input int x, input int y, input int w,
			input int h, input int v, input int a);
		item_t it;
		it.op           = op;
		it.pos_x        = x[9:0];
		it.pos_y        = y[9:0];
		it.width        = w[8:0];
		it.height       = h[8:0];
		it.pixel_value  = v[7:0];
		it.read_address = a[15:0];
		return it;
	endfunction

	function automatic int near_pos(input int span);
		if ($urandom_range(9) == 0)
			return int'($urandom_range(0, 1023)) - 512;
		return int'($urandom_range(0, span + 15)) - 8;
	endfunction

	task automatic send(input item_t it);
		if (!calm && $urandom_range(99) < 35) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.op           <= it.op;
		req_if.pos_x        <= it.pos_x;
		req_if.pos_y        <= it.pos_y;
		req_if.width        <= it.width;
		req_if.height       <= it.height;
		req_if.pixel_value  <= it.pixel_value;
		req_if.read_address <= it.read_address;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sent++;
	endtask

	// read a byte on screen, or any written byte when the point is off screen
	task automatic read_at(input int x, input int y);
		int a;
		if (x >= 0 && x < SCREEN_COLS && y >= 0 && y < SCREEN_LINES)
			a = y * SCREEN_COLS + x;
		else
			a = $urandom_range(0, STORE_DEPTH - 1);
		send(mk(OP_READ, $urandom_range(1023), $urandom_range(1023), $urandom_range(511),
			$urandom_range(511), $urandom_range(255), a));
	endtask

	initial begin
		int n_directed;
		int pick;
		int x, y, w, h, n, v;
		logic [7:0] pix_seq [6];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole-screen clear first so every later in-range read hits a written byte
		send(mk(OP_FILL, 0, 0, SCREEN_COLS, SCREEN_LINES, 8'h5a, 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, STORE_DEPTH - 1));
		send(mk(OP_FILL, -512, -512, 511, 511, 8'hff, 0));
		send(mk(OP_FILL, 511, 511, 511, 511, 8'hff, 65535));
		send(mk(OP_FILL, 10, 10, 0, 5, 8'hff, 0));
		send(mk(OP_FILL, 10, 10, 5, 0, 8'hff, 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, 10 * SCREEN_COLS + 10));
		send(mk(OP_FILL, SCREEN_COLS - 1, SCREEN_LINES - 1, 1, 1, 8'h81, 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, STORE_DEPTH - 1));
		send(mk(OP_FILL, -5, -3, 10, 8, 8'h3c, 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, 4 * SCREEN_COLS + 4));
		send(mk(OP_READ, 0, 0, 0, 0, 0, STORE_DEPTH));
		send(mk(OP_READ, -1, -1, 511, 511, 255, 65535));
		send(mk(OP_PIXEL, 0, 0, 0, 0, 8'h07, 0));
		send(mk(OP_HEADER, 5, 5, 0, 3, 0, 0));
		send(mk(OP_PIXEL, 0, 0, 0, 0, 8'h09, 0));
		send(mk(OP_HEADER, SCREEN_COLS - 2, SCREEN_LINES - 2, 3, 2, 0, 0));
		pix_seq = '{8'h11, 8'h00, 8'h22, 8'h33, 8'h00, 8'h44};
		foreach (pix_seq[k])
			send(mk(OP_PIXEL, 0, 0, 0, 0, pix_seq[k], 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, (SCREEN_LINES - 2) * SCREEN_COLS + SCREEN_COLS - 2));
		send(mk(OP_HEADER, -2, -2, 4, 4, 0, 0));
		send(mk(OP_PIXEL, 0, 0, 0, 0, 8'h01, 0));
		send(mk(OP_HEADER, -512, -512, 511, 511, 0, 0));
		send(mk(OP_PIXEL, 0, 0, 0, 0, 8'hff, 0));
		send(mk(OP_HEADER, 20, 30, 1, 1, 0, 0));
		send(mk(OP_PIXEL, 0, 0, 0, 0, 8'h55, 0));
		send(mk(OP_READ, 0, 0, 0, 0, 0, 30 * SCREEN_COLS + 20));
		n_directed = sent;

		while (sent < n_directed + RANDOM_ITEMS) begin
			calm = (sent - n_directed >= 250) && (sent - n_directed < 400);
			pick = $urandom_range(99);
			if (pick < 35) begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 6);
				if ($urandom_range(19) == 0) begin
					if ($urandom_range(1) != 0)
						w = 0;
					else
						h = 0;
				end
				x = near_pos(SCREEN_COLS);
				y = near_pos(SCREEN_LINES);
				send(mk(OP_HEADER, x, y, w, h, $urandom_range(255), $urandom_range(65535)));
				n = w * h;
				if (n == 0)
					n = $urandom_range(1, 2);
				else if ($urandom_range(7) == 0)
					n = $urandom_range(0, n - 1);
				repeat (n) begin
					v = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 255);
					send(mk(OP_PIXEL, $urandom_range(1023), $urandom_range(1023),
						$urandom_range(511), $urandom_range(511), v, $urandom_range(65535)));
				end
				read_at(x + (w > 0 ? $urandom_range(0, w - 1) : 0),
					y + (h > 0 ? $urandom_range(0, h - 1) : 0));
			end else if (pick < 60) begin
				if ($urandom_range(39) == 0) begin
					w = $urandom_range(0, 511);
					h = $urandom_range(0, 511);
				end else begin
					w = $urandom_range(0, 24);
					h = $urandom_range(0, 24);
				end
				x = near_pos(SCREEN_COLS);
				y = near_pos(SCREEN_LINES);
				send(mk(OP_FILL, x, y, w, h, $urandom_range(255), $urandom_range(65535)));
				read_at(x + (w > 0 ? $urandom_range(0, w - 1) : 0),
					y + (h > 0 ? $urandom_range(0, h - 1) : 0));
			end else if (pick < 85) begin
				send(mk(OP_READ, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(511), $urandom_range(511), $urandom_range(255),
					($urandom_range(9) == 0) ? $urandom_range(65535)
						: $urandom_range(0, STORE_DEPTH - 1)));
			end else begin
				// noise: any op with raw fields, fills kept short
				v = $urandom_range(3);
				w = (op_t'(v) == OP_FILL) ? $urandom_range(31) : $urandom_range(511);
				h = (op_t'(v) == OP_FILL) ? $urandom_range(31) : $urandom_range(511);
				send(mk(op_t'(v), $urandom_range(1023), $urandom_range(1023), w, h,
					$urandom_range(255), $urandom_range(65535)));
			end
		end
		calm = 1'b0;
		req_if.valid <= 1'b0;

		do
			@(posedge clk);
		while (chk_pending != 0);
		repeat (20) @(posedge clk);

		if (chk_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ckb_pkg.sv
hw/rtl/ckb_if.sv
hw/rtl/ckb_ram.sv
hw/rtl/ckb_ctrl.sv
hw/rtl/ckb_datapath.sv
hw/rtl/clipped_fill_and_keyed_blit.sv
bench/ckb_blit_checker.sv
bench/tb_clipped_fill_and_keyed_blit.sv
